// File: rtl/core/pmmu_pkg.sv
package pmmu_pkg;

  // address geometry
  localparam int PAGE_BITS   = 6;
  localparam int FRAME_BITS  = 4;
  localparam int OFFSET_BITS = 10;
  localparam int NUM_PAGES   = 1 << PAGE_BITS;
  localparam int NUM_FRAMES  = 1 << FRAME_BITS;
  localparam int VA_W        = 16;
  localparam int PA_W        = FRAME_BITS + OFFSET_BITS;

  // counter widths
  localparam int REF_W    = 32;
  localparam int USED_W   = FRAME_BITS + 1;
  localparam int MAPPED_W = PAGE_BITS + 1;

  // opcodes
  localparam logic [2:0] OP_READ  = 3'd0;
  localparam logic [2:0] OP_WRITE = 3'd1;
  localparam logic [2:0] OP_MAP   = 3'd2;
  localparam logic [2:0] OP_UNMAP = 3'd3;
  localparam logic [2:0] OP_TICK  = 3'd4;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FAULT     = 3'd1;
  localparam logic [2:0] ST_NOFRAME   = 3'd2;
  localparam logic [2:0] ST_MAPPED    = 3'd3;
  localparam logic [2:0] ST_NOTMAPPED = 3'd4;

  typedef struct packed {
    logic [2:0]      opcode;
    logic [VA_W-1:0] vaddr;
  } in_item_t;

  typedef struct packed {
    logic [2:0]            status;
    logic [PA_W-1:0]       paddr;
    logic [PAGE_BITS-1:0]  vpn;
    logic [FRAME_BITS-1:0] pfn;
    logic [USED_W-1:0]     used_frames;
    logic [MAPPED_W-1:0]   mapped_pages;
  } out_item_t;

  // state updates decided for one item
  typedef struct packed {
    logic                  present_set;
    logic                  present_clr;
    logic                  frame_we;
    logic [FRAME_BITS-1:0] frame_wdata;
    logic                  fu_set;
    logic                  fu_clr;
    logic [FRAME_BITS-1:0] fu_idx;
    logic                  ref_we;
    logic [REF_W-1:0]      ref_wdata;
    logic                  mod_set;
    logic                  mod_clr;
    logic                  tick;
    logic [USED_W-1:0]     used_nxt;
    logic [MAPPED_W-1:0]   mapped_nxt;
  } upd_t;

endpackage

// File: rtl/core/paged_mmu_with_frame_allocator.sv
// an input beat passes the input register and then the result register before its result beat
// throughput: one beat per cycle while out_ready holds; page state, frame bitmap and counters live in flops
// and are updated as an item leaves the input register, so the next item sees them
// frame numbers sit in a registered-read ram, read as the input beat is taken
// reset (rst_n low, synchronous): pipeline empty, page table, bitmap, counters
// and replacement mode cleared; no clearing pass is needed
module paged_mmu_with_frame_allocator (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pmmu_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output pmmu_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_wdata
);

  localparam int PB = pmmu_pkg::PAGE_BITS;
  localparam int FB = pmmu_pkg::FRAME_BITS;
  localparam int OB = pmmu_pkg::OFFSET_BITS;

  logic                             stage_v_r, stage_v_nxt;
  pmmu_pkg::in_item_t               stage_r;
  logic                             out_v_r, out_v_nxt;
  pmmu_pkg::out_item_t              out_r;
  logic                             mode_r;
  logic [pmmu_pkg::NUM_PAGES-1:0]   page_present_r, page_present_nxt;
  logic [pmmu_pkg::NUM_PAGES-1:0]   page_mod_r, page_mod_nxt;
  logic [pmmu_pkg::NUM_PAGES-1:0]   ref_vld_r, ref_vld_nxt;
  logic [pmmu_pkg::NUM_FRAMES-1:0]  frame_used_r, frame_used_nxt;
  logic [pmmu_pkg::REF_W-1:0]       instr_r;
  logic [pmmu_pkg::USED_W-1:0]      used_r;
  logic [pmmu_pkg::MAPPED_W-1:0]    mapped_r;
  logic                             byp_r;
  logic [FB-1:0]                    byp_data_r;
  logic                             ref_vld_q_r;

  logic                             adv;
  logic                             acc;
  logic [PB-1:0]                    in_page;
  logic [PB-1:0]                    stage_page;
  logic [FB-1:0]                    frame_q;
  logic [FB-1:0]                    frame_rd;
  logic                             frame_we;
  logic                             ref_we;
  logic [pmmu_pkg::REF_W-1:0]       ref_q;
  logic [pmmu_pkg::REF_W-1:0]       ref_rd;
  pmmu_pkg::upd_t                   upd;
  pmmu_pkg::out_item_t              res;

  // handshake
  assign adv      = stage_v_r && (!out_v_r || out_ready);
  assign in_ready = !stage_v_r || adv;
  assign acc      = in_valid && in_ready;
  assign stage_v_nxt = acc || (stage_v_r && !adv);
  assign out_v_nxt   = adv || (out_v_r && !out_ready);

  assign in_page    = in_data.vaddr[OB +: PB];
  assign stage_page = stage_r.vaddr[OB +: PB];

  // page frame table, read as the beat enters the input register
  assign frame_we = adv && upd.frame_we;

  pmmu_ram #(
    .WIDTH (FB),
    .DEPTH (pmmu_pkg::NUM_PAGES)
  ) u_frame_ram (
    .clk   (clk),
    .we    (frame_we),
    .waddr (stage_page),
    .wdata (upd.frame_wdata),
    .re    (acc),
    .raddr (in_page),
    .rdata (frame_q)
  );

  // forward a frame written in the same cycle the next beat read it
  always_ff @(posedge clk) begin
    if (acc) begin
      byp_r      <= frame_we && (stage_page == in_page);
      byp_data_r <= upd.frame_wdata;
    end
  end

  assign frame_rd = byp_r ? byp_data_r : frame_q;

  // reference stamps, one per page
  assign ref_we = adv && upd.ref_we;

  pmmu_ram #(
    .WIDTH (pmmu_pkg::REF_W),
    .DEPTH (pmmu_pkg::NUM_PAGES)
  ) u_ref_ram (
    .clk   (clk),
    .we    (ref_we),
    .waddr (stage_page),
    .wdata (upd.ref_wdata),
    .re    (1'b1),
    .raddr (stage_page),
    .rdata (ref_q)
  );

  always_ff @(posedge clk) begin
    ref_vld_q_r <= ref_vld_r[stage_page];
  end

  // a stamp never written reads as zero
  assign ref_rd = ref_vld_q_r ? ref_q : '0;

  // decision logic
  pmmu_exec u_exec (
    .item         (stage_r),
    .mode         (mode_r),
    .page_present (page_present_r),
    .frame_used   (frame_used_r),
    .frame_rd     (frame_rd),
    .instr_cnt    (instr_r),
    .used_cnt     (used_r),
    .mapped_cnt   (mapped_r),
    .upd          (upd),
    .res          (res)
  );

  // per-page and per-frame bit updates
  always_comb begin
    page_present_nxt = page_present_r;
    page_mod_nxt     = page_mod_r;
    ref_vld_nxt      = ref_vld_r;
    frame_used_nxt   = frame_used_r;
    if (adv) begin
      if (upd.present_set) begin
        page_present_nxt[stage_page] = 1'b1;
      end
      if (upd.present_clr) begin
        page_present_nxt[stage_page] = 1'b0;
      end
      if (upd.mod_set) begin
        page_mod_nxt[stage_page] = 1'b1;
      end
      if (upd.mod_clr) begin
        page_mod_nxt[stage_page] = 1'b0;
      end
      if (upd.ref_we) begin
        ref_vld_nxt[stage_page] = 1'b1;
      end
      if (upd.fu_set) begin
        frame_used_nxt[upd.fu_idx] = 1'b1;
      end
      if (upd.fu_clr) begin
        frame_used_nxt[upd.fu_idx] = 1'b0;
      end
    end
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r      <= 1'b0;
      out_v_r        <= 1'b0;
      mode_r         <= 1'b0;
      page_present_r <= '0;
      page_mod_r     <= '0;
      ref_vld_r      <= '0;
      frame_used_r   <= '0;
      instr_r        <= '0;
      used_r         <= '0;
      mapped_r       <= '0;
    end else begin
      stage_v_r      <= stage_v_nxt;
      out_v_r        <= out_v_nxt;
      page_present_r <= page_present_nxt;
      page_mod_r     <= page_mod_nxt;
      ref_vld_r      <= ref_vld_nxt;
      frame_used_r   <= frame_used_nxt;
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
      if (adv) begin
        used_r   <= upd.used_nxt;
        mapped_r <= upd.mapped_nxt;
        if (upd.tick) begin
          instr_r <= instr_r + pmmu_pkg::REF_W'(1);
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (acc) begin
      stage_r <= in_data;
    end
    if (adv) begin
      out_r <= res;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // frame count tracks the bitmap
  a_used_count : assert property (@(posedge clk) disable iff (!rst_n)
    used_r == pmmu_pkg::USED_W'($countones(frame_used_r)))
    else $error("used frame count disagrees with frame bitmap");

  // page count tracks the present bits
  a_mapped_count : assert property (@(posedge clk) disable iff (!rst_n)
    mapped_r == pmmu_pkg::MAPPED_W'($countones(page_present_r)))
    else $error("mapped page count disagrees with present bits");

  // a stamp written and then read back with no write between returns what was written
  a_ref_readback : assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n, 1) && $past(rst_n, 2) && $past(ref_we, 2) && !$past(ref_we, 1) &&
     ($past(stage_page, 2) == $past(stage_page, 1)))
    |-> (ref_rd == $past(upd.ref_wdata, 2)))
    else $error("reference stamp read back wrong");

endmodule

// File: rtl/core/pmmu_ram.sv
module pmmu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/pmmu_frame_alloc.sv
module pmmu_frame_alloc (
  input  logic [pmmu_pkg::NUM_FRAMES-1:0] frame_used,
  output logic                            found,
  output logic [pmmu_pkg::FRAME_BITS-1:0] idx
);

  // lowest free frame wins
  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = pmmu_pkg::NUM_FRAMES - 1; i >= 0; i--) begin
      if (!frame_used[i]) begin
        found = 1'b1;
        idx   = pmmu_pkg::FRAME_BITS'(i);
      end
    end
  end

endmodule

// File: rtl/core/pmmu_exec.sv
module pmmu_exec (
  input  pmmu_pkg::in_item_t                 item,
  input  logic                               mode,
  input  logic [pmmu_pkg::NUM_PAGES-1:0]     page_present,
  input  logic [pmmu_pkg::NUM_FRAMES-1:0]    frame_used,
  input  logic [pmmu_pkg::FRAME_BITS-1:0]    frame_rd,
  input  logic [pmmu_pkg::REF_W-1:0]         instr_cnt,
  input  logic [pmmu_pkg::USED_W-1:0]        used_cnt,
  input  logic [pmmu_pkg::MAPPED_W-1:0]      mapped_cnt,
  output pmmu_pkg::upd_t                     upd,
  output pmmu_pkg::out_item_t                res
);

  logic [pmmu_pkg::PAGE_BITS-1:0]   page;
  logic [pmmu_pkg::OFFSET_BITS-1:0] offset;
  logic                             pres;
  logic                             alloc_found;
  logic [pmmu_pkg::FRAME_BITS-1:0]  alloc_idx;

  assign page   = item.vaddr[pmmu_pkg::OFFSET_BITS +: pmmu_pkg::PAGE_BITS];
  assign offset = item.vaddr[pmmu_pkg::OFFSET_BITS-1:0];
  assign pres   = page_present[page];

  pmmu_frame_alloc u_alloc (
    .frame_used (frame_used),
    .found      (alloc_found),
    .idx        (alloc_idx)
  );

  // decode one item into its result and state updates
  always_comb begin
    upd            = '0;
    res            = '0;
    upd.used_nxt   = used_cnt;
    upd.mapped_nxt = mapped_cnt;
    res.status     = pmmu_pkg::ST_OK;
    res.vpn        = page;
    case (item.opcode)
      pmmu_pkg::OP_READ, pmmu_pkg::OP_WRITE: begin
        if (!pres) begin
          res.status = pmmu_pkg::ST_FAULT;
        end else begin
          res.pfn       = frame_rd;
          res.paddr     = {frame_rd, offset};
          upd.ref_we    = 1'b1;
          upd.ref_wdata = mode ? pmmu_pkg::REF_W'(1) : instr_cnt;
          upd.mod_set   = (item.opcode == pmmu_pkg::OP_WRITE);
        end
      end
      pmmu_pkg::OP_MAP: begin
        if (pres) begin
          res.status = pmmu_pkg::ST_MAPPED;
          res.pfn    = frame_rd;
        end else if (!alloc_found) begin
          res.status = pmmu_pkg::ST_NOFRAME;
        end else begin
          res.pfn          = alloc_idx;
          upd.fu_set       = 1'b1;
          upd.fu_idx       = alloc_idx;
          upd.used_nxt     = used_cnt + pmmu_pkg::USED_W'(1);
          upd.present_set  = 1'b1;
          upd.mod_clr      = 1'b1;
          upd.ref_we       = 1'b1;
          upd.ref_wdata    = '0;
          upd.frame_we     = 1'b1;
          upd.frame_wdata  = alloc_idx;
          upd.mapped_nxt   = mapped_cnt + pmmu_pkg::MAPPED_W'(1);
        end
      end
      pmmu_pkg::OP_UNMAP: begin
        if (!pres) begin
          res.status = pmmu_pkg::ST_NOTMAPPED;
        end else begin
          res.pfn = frame_rd;
          if (frame_used[frame_rd]) begin
            upd.fu_clr   = 1'b1;
            upd.fu_idx   = frame_rd;
            upd.used_nxt = used_cnt - pmmu_pkg::USED_W'(1);
          end
          upd.present_clr = 1'b1;
          upd.mapped_nxt  = mapped_cnt - pmmu_pkg::MAPPED_W'(1);
        end
      end
      pmmu_pkg::OP_TICK: begin
        upd.tick = 1'b1;
      end
      default: begin
      end
    endcase
    res.used_frames  = upd.used_nxt;
    res.mapped_pages = upd.mapped_nxt;
  end

endmodule
